// File: design/ptbl_pkg.sv
// ---------------------------------------------------------------------------
// ptbl_pkg
// Shared constants, types and the set hash of the per-client token bucket
// limiter.
// ---------------------------------------------------------------------------
package ptbl_pkg;

    // Table geometry; SETS must be a power of two (set index is the hash low bits)
    localparam int SETS  = 256;
    localparam int WAYS  = 4;
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int RATE_W  = 16;
    localparam int BURST_W = 16;
    localparam int AGE_W   = 8;
    localparam int TOK_W   = 18;
    localparam int LEFT_W  = 17;
    localparam int STAT_W  = 2;
    localparam int PROD_W  = TIME_W + RATE_W;
    localparam int SUM_W   = PROD_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE   = 2'd2;

    localparam logic [RATE_W-1:0]  RATE_RST  = 16'd10;
    localparam logic [BURST_W-1:0] BURST_RST = 16'd20;
    localparam logic [AGE_W-1:0]   AGE_RST   = 8'd60;

    localparam logic [31:0] DJB2_SEED = 32'd5381;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_PASS   = 2'd0,
        ST_REJECT = 2'd1,
        ST_NEW    = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // One way of a table row
    typedef struct packed {
        logic                     valid;
        logic [ADDR_W-1:0]        addr;
        logic signed [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0]        last;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;
    localparam int ROW_W = $bits(t_row);

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic eval;
        logic mult;
        logic commit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_stat;

    // djb2 over the four address bytes, MSB first; only the low bits survive
    function automatic logic [SET_W-1:0] pick_set(input logic [ADDR_W-1:0] addr);
        logic [31:0] h;
        h = DJB2_SEED;
        for (int i = 3; i >= 0; i--) begin
            h = (h << 5) + h + {24'd0, addr[8*i +: 8]};
        end
        return h[SET_W-1:0];
    endfunction

endpackage

// File: design/ptbl_req_if.sv
// ---------------------------------------------------------------------------
// ptbl_req_if
// Request channel: client address and current time, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ptbl_req_if;
    logic                         valid;
    logic                         ready;
    logic [ptbl_pkg::ADDR_W-1:0]  client_addr;
    logic [ptbl_pkg::TIME_W-1:0]  now_sec;

    modport source (output valid, output client_addr, output now_sec, input ready);
    modport sink   (input valid, input client_addr, input now_sec, output ready);
endinterface

// File: design/ptbl_rsp_if.sv
// ---------------------------------------------------------------------------
// ptbl_rsp_if
// Result channel: pass/reject verdict, status and remaining tokens.
// ---------------------------------------------------------------------------
interface ptbl_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                allowed;
    logic [ptbl_pkg::STAT_W-1:0]         status;
    logic signed [ptbl_pkg::LEFT_W-1:0]  tokens_left;

    modport source (output valid, output allowed, output status, output tokens_left,
                    input ready);
    modport sink   (input valid, input allowed, input status, input tokens_left,
                    output ready);
endinterface

// File: design/per_client_token_bucket_limiter_core.sv
// ---------------------------------------------------------------------------
// per_client_token_bucket_limiter_core
// Steps: table read, evaluate, refill multiply, write-back; the result word is
// registered at write-back. A new request is taken only after write-back, which
// waits while the result word is held by the sink.
// Reset: synchronous, active low; clears config to defaults and all row flags,
// so the table reads empty at once with no clearing pass.
// ---------------------------------------------------------------------------
module per_client_token_bucket_limiter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ptbl_req_if.sink                        i_req,
    ptbl_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [ptbl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptbl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ptbl_pkg::t_cmd  cmd;
    ptbl_pkg::t_stat stat;

    // Sequencer
    ptbl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath
    ptbl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_client_addr (i_req.client_addr),
        .i_now_sec     (i_req.now_sec),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_allowed     (o_rsp.allowed),
        .o_status      (o_rsp.status),
        .o_tokens_left (o_rsp.tokens_left)
    );

endmodule

// File: design/ptbl_ram.sv
// ---------------------------------------------------------------------------
// ptbl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ptbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ptbl_ctrl.sv
// ---------------------------------------------------------------------------
// ptbl_ctrl
// Request sequencer: accept, evaluate the set, refill multiply, commit.
// ---------------------------------------------------------------------------
module ptbl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  ptbl_pkg::t_stat i_stat,
    output ptbl_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_MULT  = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                // wait for room in the output register
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/ptbl_dp.sv
// ---------------------------------------------------------------------------
// ptbl_dp
// Datapath: config registers, set table, stale/hit search, refill and
// token update, output register.
// ---------------------------------------------------------------------------
module ptbl_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ptbl_pkg::t_cmd                     i_cmd,
    output ptbl_pkg::t_stat                    o_stat,
    input  logic [ptbl_pkg::ADDR_W-1:0]        i_client_addr,
    input  logic [ptbl_pkg::TIME_W-1:0]        i_now_sec,
    input  logic                               i_cfg_we,
    input  logic [ptbl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ptbl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_allowed,
    output logic [ptbl_pkg::STAT_W-1:0]        o_status,
    output logic signed [ptbl_pkg::LEFT_W-1:0] o_tokens_left
);

    // Configuration
    logic [ptbl_pkg::RATE_W-1:0]  r_rate;
    logic [ptbl_pkg::BURST_W-1:0] r_burst;
    logic [ptbl_pkg::AGE_W-1:0]   r_age;

    // Request word and set
    logic [ptbl_pkg::ADDR_W-1:0]  r_addr;
    logic [ptbl_pkg::TIME_W-1:0]  r_now;
    logic [ptbl_pkg::SET_W-1:0]   r_set;
    logic [ptbl_pkg::SET_W-1:0]   set_in;

    // Row-written flags; an unwritten row reads as all ways free
    logic [ptbl_pkg::SETS-1:0]    r_row_valid;
    logic                         r_row_ok;

    // Table memory
    logic [ptbl_pkg::ROW_W-1:0]   ram_rdata;
    ptbl_pkg::t_row               row_rd;
    ptbl_pkg::t_row               n_row_wr;

    // Evaluation
    logic [ptbl_pkg::WAYS-1:0]    keep;
    logic [ptbl_pkg::TIME_W-1:0]  el [ptbl_pkg::WAYS];
    logic                         hit, free;
    logic [ptbl_pkg::WAY_W-1:0]   hit_way, free_way;
    ptbl_pkg::t_row               row_kept;
    ptbl_pkg::t_row               r_row;
    logic                         r_hit, r_free;
    logic [ptbl_pkg::WAY_W-1:0]   r_hit_way, r_free_way;
    logic [ptbl_pkg::TIME_W-1:0]  r_el;
    logic signed [ptbl_pkg::TOK_W-1:0] r_tok;

    // Refill
    logic [ptbl_pkg::PROD_W-1:0]       r_prod;
    logic signed [ptbl_pkg::SUM_W-1:0] sum, burst_x, capped;
    logic signed [ptbl_pkg::TOK_W-1:0] t_fill, t_new, t_first;
    logic                              passes;

    // Result
    logic                               n_allowed;
    ptbl_pkg::t_status                  n_status;
    logic signed [ptbl_pkg::LEFT_W-1:0] n_left;
    logic                               r_out_valid;
    logic                               r_allowed;
    logic [ptbl_pkg::STAT_W-1:0]        r_status;
    logic signed [ptbl_pkg::LEFT_W-1:0] r_left;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= ptbl_pkg::RATE_RST;
            r_burst <= ptbl_pkg::BURST_RST;
            r_age   <= ptbl_pkg::AGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptbl_pkg::CFG_RATE:  r_rate  <= i_cfg_data[ptbl_pkg::RATE_W-1:0];
                ptbl_pkg::CFG_BURST: r_burst <= i_cfg_data[ptbl_pkg::BURST_W-1:0];
                ptbl_pkg::CFG_AGE:   r_age   <= i_cfg_data[ptbl_pkg::AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture request and hash the address into a set
    assign set_in = ptbl_pkg::pick_set(i_client_addr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr   <= i_client_addr;
            r_now    <= i_now_sec;
            r_set    <= set_in;
            r_row_ok <= r_row_valid[set_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_cmd.commit) begin
            r_row_valid[r_set] <= 1'b1;
        end
    end

    ptbl_ram #(
        .WIDTH (ptbl_pkg::ROW_W),
        .DEPTH (ptbl_pkg::SETS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_set),
        .i_wdata (n_row_wr),
        .i_re    (i_cmd.load),
        .i_raddr (set_in),
        .o_rdata (ram_rdata)
    );

    assign row_rd = ptbl_pkg::t_row'(ram_rdata);

    // Per-way age check, then first matching and first free way
    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_way  = '0;
        free_way = '0;
        row_kept = row_rd;
        for (int w = 0; w < ptbl_pkg::WAYS; w++) begin
            el[w]   = (r_now >= row_rd[w].last) ? r_now - row_rd[w].last : '0;
            keep[w] = r_row_ok && row_rd[w].valid &&
                      !(el[w] > {{(ptbl_pkg::TIME_W-ptbl_pkg::AGE_W){1'b0}}, r_age});
            row_kept[w].valid = keep[w];
            if (keep[w]) begin
                if (!hit && row_rd[w].addr == r_addr) begin
                    hit     = 1'b1;
                    hit_way = w[ptbl_pkg::WAY_W-1:0];
                end
            end else if (!free) begin
                free     = 1'b1;
                free_way = w[ptbl_pkg::WAY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_row      <= row_kept;
            r_hit      <= hit;
            r_hit_way  <= hit_way;
            r_free     <= free;
            r_free_way <= free_way;
            r_el       <= el[hit_way];
            r_tok      <= row_rd[hit_way].tokens;
        end
    end

    // Refill amount
    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod <= r_el * r_rate;
        end
    end

    // Refill, cap at burst, spend one token; build the row to write back
    assign sum     = {{(ptbl_pkg::SUM_W-ptbl_pkg::TOK_W){r_tok[ptbl_pkg::TOK_W-1]}}, r_tok}
                   + $signed({2'b00, r_prod});
    assign burst_x = $signed({{(ptbl_pkg::SUM_W-ptbl_pkg::BURST_W){1'b0}}, r_burst});
    assign capped  = (sum > burst_x) ? burst_x : sum;
    assign t_fill  = capped[ptbl_pkg::TOK_W-1:0];
    assign passes  = (t_fill > $signed(ptbl_pkg::TOK_W'(0)));
    assign t_new   = passes ? t_fill - $signed(ptbl_pkg::TOK_W'(1)) : t_fill;
    assign t_first = $signed({2'b00, r_burst}) - $signed(ptbl_pkg::TOK_W'(1));

    always_comb begin
        n_row_wr  = r_row;
        n_allowed = 1'b1;
        n_status  = ptbl_pkg::ST_FULL;
        n_left    = '0;
        if (r_hit) begin
            n_row_wr[r_hit_way].tokens = t_new;
            n_row_wr[r_hit_way].last   = r_now;
            n_allowed = passes;
            if (passes) begin
                n_status = ptbl_pkg::ST_PASS;
            end else begin
                n_status = ptbl_pkg::ST_REJECT;
            end
            n_left    = t_new[ptbl_pkg::LEFT_W-1:0];
        end else if (r_free) begin
            n_row_wr[r_free_way].valid  = 1'b1;
            n_row_wr[r_free_way].addr   = r_addr;
            n_row_wr[r_free_way].tokens = t_first;
            n_row_wr[r_free_way].last   = r_now;
            n_status = ptbl_pkg::ST_NEW;
            n_left   = t_first[ptbl_pkg::LEFT_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_allowed <= n_allowed;
            r_status  <= n_status;
            r_left    <= n_left;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_allowed       = r_allowed;
    assign o_status        = r_status;
    assign o_tokens_left   = r_left;

endmodule

// File: dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-client token bucket limiter. A bucket
// table held in the bench predicts the verdict word for every accepted
// request. Each verdict word that the block returns is checked against the
// oldest prediction. Directed cases come first, then random traffic that
// crowds a few sets, under changing limits and handshake pressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_TAIL    = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int DEPTH         = ptbl_pkg::SETS * ptbl_pkg::WAYS;
    localparam int CROWD_GROUPS  = 3;
    localparam int CROWD_SIZE    = ptbl_pkg::WAYS + 2;
    localparam int REGULARS      = 24;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int REPORT_MAX    = 10;

    // Index past the register list; writes to it must change nothing
    localparam logic [ptbl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [ptbl_pkg::ADDR_W-1:0] ADDR_LOW  = '0;
    localparam logic [ptbl_pkg::ADDR_W-1:0] ADDR_HIGH = '1;
    localparam logic [ptbl_pkg::ADDR_W-1:0] ADDR_HOST = 32'hC0A8_0A01;
    localparam logic [ptbl_pkg::ADDR_W-1:0] ADDR_PEER = 32'h0A00_0002;

    // One verdict word
    typedef struct packed {
        logic                               allowed;
        logic [ptbl_pkg::STAT_W-1:0]        status;
        logic signed [ptbl_pkg::LEFT_W-1:0] tokens_left;
    } t_verdict;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [ptbl_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ptbl_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ptbl_req_if req_ch ();
    ptbl_rsp_if rsp_ch ();

    per_client_token_bucket_limiter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Bench copy of the limits and the bucket table
    logic [ptbl_pkg::RATE_W-1:0]  lim_rate;
    logic [ptbl_pkg::BURST_W-1:0] lim_burst;
    logic [ptbl_pkg::AGE_W-1:0]   lim_age;
    bit                           bkt_valid  [DEPTH];
    logic [ptbl_pkg::ADDR_W-1:0]  bkt_addr   [DEPTH];
    longint                       bkt_tokens [DEPTH];
    logic [ptbl_pkg::TIME_W-1:0]  bkt_last   [DEPTH];

    t_verdict                    expected_verdicts [$];
    logic [ptbl_pkg::ADDR_W-1:0] crowd_addr   [CROWD_GROUPS*CROWD_SIZE];
    logic [ptbl_pkg::ADDR_W-1:0] regular_addr [REGULARS];
    logic [ptbl_pkg::TIME_W-1:0] wall_sec;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold      = 1'b0;
    int mismatches   = 0;
    int cycles_run;

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // djb2 over the address bytes, high byte first, wrapping at 32 bits
    function automatic int unsigned bucket_set(input logic [ptbl_pkg::ADDR_W-1:0] addr);
        logic [31:0] h;
        int          b;
        h = ptbl_pkg::DJB2_SEED;
        for (b = ptbl_pkg::ADDR_W/8 - 1; b >= 0; b--) begin
            h = h * 33 + addr[8*b +: 8];
        end
        return h % ptbl_pkg::SETS;
    endfunction

    // Seconds since the last refill; a clock that went back counts as none
    function automatic longint seconds_since(input logic [ptbl_pkg::TIME_W-1:0] last,
                                             input logic [ptbl_pkg::TIME_W-1:0] now);
        return (now >= last) ? longint'(now) - longint'(last) : 0;
    endfunction

    // Verdict for one request; updates the bench table as the block should
    function automatic t_verdict predict_request(input logic [ptbl_pkg::ADDR_W-1:0] addr,
                                                 input logic [ptbl_pkg::TIME_W-1:0] now);
        int       base;
        int       hit;
        int       spare;
        int       k;
        int       w;
        longint   fill;
        t_verdict v;
        base  = int'(bucket_set(addr)) * ptbl_pkg::WAYS;
        hit   = -1;
        spare = -1;
        // age out stale ways, then find the client and the lowest free way
        for (w = 0; w < ptbl_pkg::WAYS; w++) begin
            k = base + w;
            if (bkt_valid[k] && seconds_since(bkt_last[k], now) > longint'(lim_age)) begin
                bkt_valid[k] = 1'b0;
            end
            if (bkt_valid[k]) begin
                if (hit < 0 && bkt_addr[k] == addr) begin
                    hit = w;
                end
            end else if (spare < 0) begin
                spare = w;
            end
        end
        if (hit >= 0) begin
            // refill, cap at burst, then spend one token if there is one
            k    = base + hit;
            fill = bkt_tokens[k] + seconds_since(bkt_last[k], now) * longint'(lim_rate);
            if (fill > longint'(lim_burst)) begin
                fill = longint'(lim_burst);
            end
            bkt_last[k] = now;
            if (fill >= 1) begin
                fill      = fill - 1;
                v.allowed = 1'b1;
                v.status  = ptbl_pkg::ST_PASS;
            end else begin
                v.allowed = 1'b0;
                v.status  = ptbl_pkg::ST_REJECT;
            end
            bkt_tokens[k] = fill;
            v.tokens_left = fill[ptbl_pkg::LEFT_W-1:0];
        end else if (spare >= 0) begin
            k             = base + spare;
            bkt_valid[k]  = 1'b1;
            bkt_addr[k]   = addr;
            bkt_tokens[k] = longint'(lim_burst) - 1;
            bkt_last[k]   = now;
            v.allowed     = 1'b1;
            v.status      = ptbl_pkg::ST_NEW;
            v.tokens_left = bkt_tokens[k][ptbl_pkg::LEFT_W-1:0];
        end else begin
            v.allowed     = 1'b1;
            v.status      = ptbl_pkg::ST_FULL;
            v.tokens_left = '0;
        end
        return v;
    endfunction

    // Offer one request word, with random idle cycles ahead of it
    task automatic send_request(input logic [ptbl_pkg::ADDR_W-1:0] addr,
                                input logic [ptbl_pkg::TIME_W-1:0] now);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.client_addr <= addr;
        req_ch.now_sec     <= now;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_verdicts.push_back(predict_request(addr, now));
    endtask

    // Stop offering and wait for every outstanding verdict
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_verdicts.size() != 0);
    endtask

    task automatic write_reg(input logic [ptbl_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [ptbl_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ptbl_pkg::CFG_RATE:  lim_rate  = data[ptbl_pkg::RATE_W-1:0];
            ptbl_pkg::CFG_BURST: lim_burst = data[ptbl_pkg::BURST_W-1:0];
            ptbl_pkg::CFG_AGE:   lim_age   = data[ptbl_pkg::AGE_W-1:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [ptbl_pkg::RATE_W-1:0]  rate,
                              input logic [ptbl_pkg::BURST_W-1:0] burst,
                              input logic [ptbl_pkg::AGE_W-1:0]   age);
        write_reg(ptbl_pkg::CFG_RATE, rate);
        write_reg(ptbl_pkg::CFG_BURST, burst);
        write_reg(ptbl_pkg::CFG_AGE,
                  {{(ptbl_pkg::CFG_DATA_W-ptbl_pkg::AGE_W){1'b0}}, age});
    endtask

    // Reset limits, address and time extremes on an empty table
    task automatic test_fresh_table();
        send_request(ADDR_LOW, '0);
        send_request(ADDR_LOW, '0);
        send_request(ADDR_HIGH, '1);
        send_request(ADDR_HIGH, '1);
    endtask

    // Zero burst: new client passes on -1, then stays rejected
    task automatic test_zero_burst();
        drain_results();
        set_limits('0, '0, '1);
        write_reg(CFG_SPARE, '1);
        send_request(ADDR_HOST, 32'd100);
        send_request(ADDR_HOST, 32'd101);
        drain_results();
        write_reg(ptbl_pkg::CFG_RATE, 16'd5);
        send_request(ADDR_HOST, 32'd110);
    endtask

    // One set filled past its ways, then a bucket emptied to rejection
    task automatic test_full_set();
        int i;
        drain_results();
        set_limits(16'd1, 16'd3, 8'd255);
        for (i = 0; i < ptbl_pkg::WAYS + 1; i++) begin
            send_request(crowd_addr[i], 32'd200);
        end
        for (i = 0; i < 3; i++) begin
            send_request(crowd_addr[0], 32'd200);
        end
    endtask

    // Clock going back: no refill, last refill time moves back too
    task automatic test_time_backwards();
        send_request(crowd_addr[0], 32'd150);
        send_request(crowd_addr[0], 32'd152);
    endtask

    // Zero max age: any elapsed second evicts
    task automatic test_stale_eviction();
        drain_results();
        write_reg(ptbl_pkg::CFG_AGE, '0);
        send_request(crowd_addr[0], 32'd153);
        send_request(crowd_addr[ptbl_pkg::WAYS], 32'd300);
    endtask

    // Full-scale limits, then burst lowered under a full bucket
    task automatic test_burst_lowered();
        drain_results();
        set_limits('1, '1, '1);
        send_request(ADDR_PEER, 32'd1000);
        send_request(ADDR_PEER, 32'd1001);
        drain_results();
        write_reg(ptbl_pkg::CFG_BURST, 16'd7);
        send_request(ADDR_PEER, 32'd1001);
    endtask

    // Sink held off while requests keep coming, then a full sender pause
    task automatic test_backpressure();
        int i;
        drain_results();
        set_limits(16'd2, 16'd6, 8'd30);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (i = 0; i < 40; i++) begin
            send_request(crowd_addr[i % CROWD_SIZE], 32'd5000 + i / 4);
        end
        // sender rests until every verdict is back
        drain_results();
        for (i = 0; i < 10; i++) begin
            send_request(crowd_addr[i % 3], 32'd5010 + i);
        end
    endtask

    // Random clients and times under several limit settings and idle patterns
    task automatic test_random_traffic();
        int                          p;
        int                          i;
        int                          r;
        logic [ptbl_pkg::ADDR_W-1:0] addr;
        wall_sec = 32'd400;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            case (p)
                0: set_limits('1, '1, '1);
                1: set_limits('0, '0, '0);
                5: set_limits(ptbl_pkg::RATE_W'($urandom_range(65535)),
                              ptbl_pkg::BURST_W'($urandom_range(65535)),
                              ptbl_pkg::AGE_W'($urandom_range(255)));
                default: set_limits(ptbl_pkg::RATE_W'($urandom_range(4)),
                                    ptbl_pkg::BURST_W'($urandom_range(12)),
                                    ptbl_pkg::AGE_W'($urandom_range(40, 2)));
            endcase
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
                default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // mostly repeats in the same second, now and then a jump or a step back
                r = $urandom_range(99);
                if (r >= 97) begin
                    wall_sec = $urandom;
                end else if (r >= 93) begin
                    wall_sec = wall_sec - $urandom_range(20, 1);
                end else if (r >= 85) begin
                    wall_sec = wall_sec + $urandom_range(int'(lim_age) + 5);
                end else if (r >= 55) begin
                    wall_sec = wall_sec + $urandom_range(3, 1);
                end
                // crowded sets most of the time, so ways fill and buckets run dry
                r = $urandom_range(99);
                if (r < 60) begin
                    addr = crowd_addr[$urandom_range(CROWD_GROUPS*CROWD_SIZE-1)];
                end else if (r < 90) begin
                    addr = regular_addr[$urandom_range(REGULARS-1)];
                end else begin
                    addr = $urandom;
                end
                send_request(addr, wall_sec);
            end
        end
    endtask

    // Sink side: random stalls, and each accepted verdict word checked
    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        t_verdict got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.allowed     = rsp_ch.allowed;
            got.status      = rsp_ch.status;
            got.tokens_left = rsp_ch.tokens_left;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected verdict: allowed %0d status %0d tokens_left %0d",
                             got.allowed, got.status, got.tokens_left);
                end
            end else begin
                want = expected_verdicts.pop_front();
                if (got.allowed !== want.allowed || got.status !== want.status ||
                    got.tokens_left !== want.tokens_left) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("verdict mismatch (exp/got): allowed %0d/%0d status %0d/%0d %s",
                                 want.allowed, got.allowed, want.status, got.status,
                                 $sformatf("tokens_left %0d/%0d",
                                           want.tokens_left, got.tokens_left));
                    end
                end
            end
        end
        rsp_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // Run limit
    initial begin : watchdog
        for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) begin
            @(posedge i_clk);
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : run
        int          g;
        int          n;
        int          i;
        int unsigned target;
        logic [31:0] cand;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        req_ch.valid       = 1'b0;
        req_ch.client_addr = '0;
        req_ch.now_sec     = '0;

        // groups of addresses that share one set, more of them than ways
        for (g = 0; g < CROWD_GROUPS; g++) begin
            target = $urandom_range(ptbl_pkg::SETS-1);
            n      = 0;
            while (n < CROWD_SIZE) begin
                cand = $urandom;
                if (bucket_set(cand) == target) begin
                    crowd_addr[g*CROWD_SIZE + n] = cand;
                    n++;
                end
            end
        end
        for (i = 0; i < REGULARS; i++) begin
            regular_addr[i] = $urandom;
        end
        regular_addr[0] = ADDR_LOW;
        regular_addr[1] = ADDR_HIGH;

        // bench state as the block comes out of reset
        lim_rate  = ptbl_pkg::RATE_RST;
        lim_burst = ptbl_pkg::BURST_RST;
        lim_age   = ptbl_pkg::AGE_RST;
        foreach (bkt_valid[k]) begin
            bkt_valid[k] = 1'b0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fresh_table();
        test_zero_burst();
        test_full_set();
        test_time_backwards();
        test_stale_eviction();
        test_burst_lowered();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: per_client_token_bucket_limiter_core.f
design/ptbl_pkg.sv
design/ptbl_req_if.sv
design/ptbl_rsp_if.sv
design/ptbl_ram.sv
design/ptbl_ctrl.sv
design/ptbl_dp.sv
design/per_client_token_bucket_limiter_core.sv
dv/testbench.sv
